### hw/rtl/mec_pkg.sv
// Shared types, constants and fixed-point helpers for the Mandelbrot escape counter.
// No dependencies; imported by mec_ctrl, mec_datapath and mandelbrot_escape_counter.
package mec_pkg;

	localparam int WORD_WIDTH  = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int FRAC_BITS   = WORD_WIDTH - 4;
	localparam int IN_WIDTH    = 32;
	localparam int IN_FRAC     = 28;
	localparam int CFG_WIDTH   = 16;

	localparam int InShift = FRAC_BITS - IN_FRAC;
	localparam int InShL   = (InShift >= 0) ? InShift : 0;
	localparam int InShR   = (InShift < 0) ? -InShift : 0;
	localparam int LoadW   = WORD_WIDTH + IN_WIDTH;

	typedef logic signed [WORD_WIDTH-1:0]   word_t;
	typedef logic signed [2*WORD_WIDTH-1:0] prod_t;
	typedef logic [COUNT_WIDTH-1:0]         count_t;
	typedef logic [CFG_WIDTH-1:0]           cfg_t;

	localparam logic [CFG_WIDTH-1:0] MaxIterReset = CFG_WIDTH'(256);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVAL,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mult;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic limit_hit;
		logic escaped;
	} dp_stat_t;

	// saturate a double-width value to the signed word range
	function automatic word_t sat_word(input prod_t v);
		prod_t hi;
		prod_t lo;
		hi = prod_t'({1'b0, {(WORD_WIDTH-1){1'b1}}});
		lo = -hi - prod_t'(1);
		if (v > hi) begin
			return word_t'(hi);
		end else if (v < lo) begin
			return word_t'(lo);
		end
		return v[WORD_WIDTH-1:0];
	endfunction

	// Q4.28 input to internal word, floor on right shift
	function automatic word_t load_input(input logic signed [IN_WIDTH-1:0] raw);
		logic signed [LoadW-1:0] wide;
		wide = LoadW'(raw);
		wide = (wide <<< InShL) >>> InShR;
		return wide[WORD_WIDTH-1:0];
	endfunction

endpackage

### hw/rtl/mec_ctrl.sv
// Controller state machine for the Mandelbrot escape counter.
// Depends on mec_pkg; drives the datapath commands from its status.
module mec_ctrl import mec_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		done       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.limit_hit) begin
					state_d = ST_DONE;
				end else begin
					cmd.mult = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.escaped) begin
					state_d = ST_DONE;
				end else begin
					cmd.update = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/mec_datapath.sv
// Datapath for the Mandelbrot escape counter: z registers, three multipliers, count.
// Depends on mec_pkg; commanded by mec_ctrl.
module mec_datapath import mec_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic signed [IN_WIDTH-1:0] c_real,
	input  logic signed [IN_WIDTH-1:0] c_imag,
	input  cfg_t                       max_iterations,
	output dp_stat_t                   stat,
	output count_t                     count
);

	localparam logic [31:0] CountCap = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam logic [WORD_WIDTH:0] Four = {2'b00, 1'b1, {(WORD_WIDTH-2){1'b0}}};

	word_t  cr_q, ci_q, zr_q, zi_q;
	prod_t  prr_q, pii_q, pri_q;
	count_t count_q;

	logic [31:0]         max_ext;
	logic [31:0]         limit_ext;
	count_t              limit;
	word_t               rr, ii, ri2, diff, zr_next, zi_next;
	logic [WORD_WIDTH:0] sq_sum;

	always_comb begin
		max_ext   = 32'(max_iterations);
		limit_ext = (max_ext < CountCap) ? max_ext : CountCap;
		limit     = limit_ext[COUNT_WIDTH-1:0];
	end

	// squares and cross term from the registered products
	always_comb begin
		rr      = sat_word(prr_q >>> FRAC_BITS);
		ii      = sat_word(pii_q >>> FRAC_BITS);
		ri2     = sat_word(pri_q >>> (FRAC_BITS - 1));
		sq_sum  = {1'b0, rr} + {1'b0, ii};
		diff    = sat_word(prod_t'(rr) - prod_t'(ii));
		zr_next = sat_word(prod_t'(diff) + prod_t'(cr_q));
		zi_next = sat_word(prod_t'(ri2) + prod_t'(ci_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q <= load_input(c_real);
			ci_q <= load_input(c_imag);
			zr_q <= '0;
			zi_q <= '0;
		end else if (cmd.update) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
		end
		if (cmd.mult) begin
			prr_q <= prod_t'(zr_q) * prod_t'(zr_q);
			pii_q <= prod_t'(zi_q) * prod_t'(zi_q);
			pri_q <= prod_t'(zr_q) * prod_t'(zi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= '0;
		end else if (cmd.update) begin
			count_q <= count_q + count_t'(1);
		end
	end

	assign stat.limit_hit = (count_q >= limit);
	assign stat.escaped   = (sq_sum >= Four);
	assign count          = count_q;

endmodule

### hw/rtl/mandelbrot_escape_counter.sv
// Top level of the Mandelbrot escape counter: limit register, controller and datapath.
// Depends on mec_pkg, mec_ctrl and mec_datapath.
//
// Start a point by raising start with c_real and c_imag (Q4.28) while busy is low.
// z starts at zero and each iteration passes through ST_CHECK, which registers the three
// 32x32 products of z, then ST_EVAL, which saturates, tests |z|^2 against 4 and updates z.
// done is high in the ST_DONE cycle, entered from ST_CHECK if the limit stopped the point or
// from ST_EVAL if it escaped; iteration_count is valid only in that cycle and must be taken then.
// busy is low during the done cycle, so the next point may start there. max_iterations (reset
// 256) is written through cfg_valid/cfg_data; the user must do so only while idle, as the block does not enforce it.
module mandelbrot_escape_counter import mec_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [IN_WIDTH-1:0] c_real,
	input  logic signed [IN_WIDTH-1:0] c_imag,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	output logic                       done,
	output logic [15:0]                iteration_count
);

	cfg_t        max_iterations_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	count_t      count;
	logic [31:0] count_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iterations_q <= MaxIterReset;
		end else if (cfg_valid && cfg_ready) begin
			max_iterations_q <= cfg_data;
		end
	end

	mec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mec_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.c_real         (c_real),
		.c_imag         (c_imag),
		.max_iterations (max_iterations_q),
		.stat           (stat),
		.count          (count)
	);

	assign count_ext       = 32'(count);
	assign iteration_count = count_ext[15:0];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(count) <= 32'(max_iterations_q)))
		else $error("iteration count above limit");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not start work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");
`endif

endmodule

### bench/mandelbrot_escape_counter_tb.sv
// Self-checking bench for mandelbrot_escape_counter: a directed table, then random points
// over several iteration limits, each count checked against the table or an escape-time model.
// Depends on mec_pkg and the mandelbrot_escape_counter RTL.
module mandelbrot_escape_counter_tb;
	import mec_pkg::*;

	localparam int ClkPeriod    = 8;
	localparam int ResetCycles  = 11;
	localparam int DrainCycles  = 16;
	localparam int UsePredictor = -1;
	localparam int LongRunCap   = 5000;
	localparam int NumRows      = 24;
	localparam int NumPhases    = 8;
	localparam int FixedPhases  = 6;

	typedef struct packed {
		logic [CFG_WIDTH-1:0]       lim;
		logic [IN_WIDTH-1:0]        re;
		logic [IN_WIDTH-1:0]        im;
		logic signed [31:0]         want;
	} dir_row_t;

	localparam dir_row_t DirRows [NumRows] = '{
		'{16'd256,   32'h0000_0000, 32'h0000_0000, 256},
		'{16'd256,   32'hE000_0000, 32'h0000_0000, 1},
		'{16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1},
		'{16'd256,   32'h8000_0000, 32'h8000_0000, 1},
		'{16'd256,   32'h7FFF_FFFF, 32'h8000_0000, 1},
		'{16'd256,   32'h8000_0000, 32'h7FFF_FFFF, 1},
		'{16'd256,   32'hF000_0000, 32'h0000_0000, 256},
		'{16'd256,   32'h1FFF_FFFF, 32'h0000_0000, UsePredictor},
		'{16'd256,   32'h0400_0000, 32'h0000_0000, UsePredictor},
		'{16'd256,   32'h0400_68DC, 32'h0000_0000, UsePredictor},
		'{16'd256,   32'hF400_0000, 32'h0199_999A, UsePredictor},
		'{16'd256,   32'h0000_0000, 32'h1000_0000, UsePredictor},
		'{16'd256,   32'hF800_0000, 32'h0800_0000, UsePredictor},
		'{16'd256,   32'h0000_0001, 32'hFFFF_FFFF, UsePredictor},
		'{16'd0,     32'h0000_0000, 32'h0000_0000, 0},
		'{16'd0,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
		'{16'd1,     32'h0000_0000, 32'h0000_0000, 1},
		'{16'd1,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1},
		'{16'd1,     32'hE000_0000, 32'h0000_0000, 1},
		'{16'd2,     32'h1FFF_FFFF, 32'h0000_0000, UsePredictor},
		'{16'd65535, 32'h2000_0000, 32'h0000_0000, 1},
		'{16'd65535, 32'h0000_0000, 32'h0000_0000, 65535},
		'{16'd65535, 32'h8000_0000, 32'h0000_0000, 1},
		'{16'd100,   32'h3000_0000, 32'h3000_0000, 1}
	};

	localparam int PhaseLimit [FixedPhases] = '{256, 0, 1, 65535, 1000, 3};
	localparam int PhaseItems [NumPhases]   = '{100, 20, 20, 10, 30, 30, 95, 95};

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       start     = 1'b0;
	logic                       busy;
	logic signed [IN_WIDTH-1:0] c_real    = '0;
	logic signed [IN_WIDTH-1:0] c_imag    = '0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_WIDTH-1:0]       cfg_data  = '0;
	logic                       done;
	logic [15:0]                iteration_count;

	count_t expected_counts [$];
	cfg_t   max_iter_cfg = MaxIterReset;
	int     error_count  = 0;
	int     burst_left   = 0;

	mandelbrot_escape_counter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.c_real          (c_real),
		.c_imag          (c_imag),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.iteration_count (iteration_count)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	initial begin
		#(ClkPeriod * 4_000_000);
		$display("status: fail");
		$finish;
	end

	function automatic longint clamp_word(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// exact product, floor shift, saturate
	function automatic longint scaled_product(input longint a, input longint b, input int sh);
		return clamp_word((a * b) >>> sh);
	endfunction

	function automatic longint to_internal(input logic signed [IN_WIDTH-1:0] raw);
		longint v;
		v = longint'(raw);
		if (FRAC_BITS >= IN_FRAC) begin
			return v <<< (FRAC_BITS - IN_FRAC);
		end
		return v >>> (IN_FRAC - FRAC_BITS);
	endfunction

	function automatic count_t escape_count(input logic signed [IN_WIDTH-1:0] re,
			input logic signed [IN_WIDTH-1:0] im, input cfg_t lim_cfg);
		longint cr;
		longint ci;
		longint zr;
		longint zi;
		longint rr;
		longint ii;
		longint ri2;
		longint four;
		longint cap;
		longint limit;
		longint n;
		cr    = to_internal(re);
		ci    = to_internal(im);
		zr    = 0;
		zi    = 0;
		n     = 0;
		four  = longint'(1) <<< (WORD_WIDTH - 2);
		cap   = (longint'(1) <<< COUNT_WIDTH) - 1;
		limit = (longint'(lim_cfg) < cap) ? longint'(lim_cfg) : cap;
		while (n < limit) begin
			rr = scaled_product(zr, zr, FRAC_BITS);
			ii = scaled_product(zi, zi, FRAC_BITS);
			if (rr + ii >= four) begin
				break;
			end
			ri2 = scaled_product(zr, zi, FRAC_BITS - 1);
			zr  = clamp_word(clamp_word(rr - ii) + cr);
			zi  = clamp_word(ri2 + ci);
			n++;
		end
		return count_t'(n);
	endfunction

	task automatic wait_idle;
		start <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input cfg_t v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_iter_cfg = v;
	endtask

	task automatic send_point(input logic signed [IN_WIDTH-1:0] re,
			input logic signed [IN_WIDTH-1:0] im, input int typed);
		start  <= 1'b1;
		c_real <= re;
		c_imag <= im;
		do @(posedge clk); while (busy);
		if (typed == UsePredictor) begin
			expected_counts.push_back(escape_count(re, im, max_iter_cfg));
		end else begin
			expected_counts.push_back(count_t'(typed));
		end
	endtask

	// bursts of back-to-back words with random gaps between them
	task automatic pace_sender;
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic random_point(output logic signed [IN_WIDTH-1:0] re,
			output logic signed [IN_WIDTH-1:0] im);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				re = $urandom;
				im = $urandom;
			end
			8, 9: begin
				// near the boundary around -0.75 + 0.1i
				re = 32'hF400_0000 + $urandom_range(0, 1 << 22) - (1 << 21);
				im = 32'h0199_999A + $urandom_range(0, 1 << 22) - (1 << 21);
			end
			default: begin
				// [-2.5, 1.0] x [-1.5, 1.5]
				re = -671088640 + $urandom_range(0, 939524096);
				im = -402653184 + $urandom_range(0, 805306368);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				$error("iteration_count: unexpected word %0d", iteration_count);
				error_count++;
			end else begin
				if (iteration_count !== expected_counts[0]) begin
					$error("iteration_count: expected %0d, actual %0d",
						expected_counts[0], iteration_count);
					error_count++;
				end
				void'(expected_counts.pop_front());
			end
		end
	end

	initial begin
		logic signed [IN_WIDTH-1:0] re;
		logic signed [IN_WIDTH-1:0] im;
		cfg_t lim;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NumRows; r++) begin
			if (DirRows[r].lim != max_iter_cfg) begin
				wait_idle();
				write_limit(DirRows[r].lim);
			end
			send_point(DirRows[r].re, DirRows[r].im, DirRows[r].want);
			pace_sender();
		end

		for (int p = 0; p < NumPhases; p++) begin
			lim = (p < FixedPhases) ? cfg_t'(PhaseLimit[p]) : cfg_t'($urandom_range(2, 512));
			wait_idle();
			write_limit(lim);
			for (int k = 0; k < PhaseItems[p]; k++) begin
				random_point(re, im);
				// keep long limits from running points deep inside the set
				while (escape_count(re, im, max_iter_cfg) > LongRunCap) random_point(re, im);
				send_point(re, im, UsePredictor);
				pace_sender();
			end
		end

		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/mec_pkg.sv
hw/rtl/mec_ctrl.sv
hw/rtl/mec_datapath.sv
hw/rtl/mandelbrot_escape_counter.sv
bench/mandelbrot_escape_counter_tb.sv
